// ----- rtl/ssr_pkg.sv -----
`default_nettype none
package ssr_pkg;

  localparam int unsigned MAX_FIND_LEN_DEF = 16;
  localparam int unsigned MAX_REPL_LEN_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIND_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_LO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_HI   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TBL,
    ST_FALL,
    ST_REL,
    ST_REPL,
    ST_LIT,
    ST_FLUSH
  } state_e;

  // Controls broadcast to the cell row.
  typedef struct packed {
    logic load;   // write byte into cell at load_idx
    logic shift;  // move every cell one place toward cell 0
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/ssr_cell.sv -----
`default_nettype none
module ssr_cell
  import ssr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire cell_ctl_t  ctl_i,
  input  wire logic       sel_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] nbr_i,
  output logic      [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.shift) begin
      byte_d = nbr_i;
    end else if (ctl_i.load && sel_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire

// ----- rtl/stream_substring_replace.sv -----
`default_nettype none
// Pass-through emits in the cycle after the transaction. Otherwise an item steps through
//   fallback, release and emit states; fallback steps never exceed the released bytes.
// Items are handled one at a time, input stalling until the last is done; output runs at
//   one emitted byte a cycle unless out_stall_i holds it.
// A pattern write while idle or rebuilding starts a fallback table build; input stalls meanwhile.
// Reset clears control and configuration registers: pass-through, nothing held.
module stream_substring_replace
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_FIND_LEN = MAX_FIND_LEN_DEF,
  parameter int unsigned MAX_REPL_LEN = MAX_REPL_LEN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  end_of_line_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [7:0]            out_byte_o,
  output logic                       run_last_o
);

  localparam int unsigned NC = MAX_FIND_LEN;
  localparam int unsigned IW = (NC > 1) ? $clog2(NC) : 1;

  // Configuration registers
  logic [LEN_W-1:0] find_len_q, repl_len_q;
  logic [63:0]      find_lo_q, find_hi_q, repl_lo_q, repl_hi_q;
  logic             tbl_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_len_q <= '0;
      repl_len_q <= '0;
      find_lo_q  <= '0;
      find_hi_q  <= '0;
      repl_lo_q  <= '0;
      repl_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIND_LEN: find_len_q <= cfg_data_i[LEN_W-1:0];
        REG_FIND_LO:  find_lo_q  <= cfg_data_i;
        REG_FIND_HI:  find_hi_q  <= cfg_data_i;
        REG_REPL_LEN: repl_len_q <= cfg_data_i[LEN_W-1:0];
        REG_REPL_LO:  repl_lo_q  <= cfg_data_i;
        REG_REPL_HI:  repl_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tbl_start = cfg_we_i && (cfg_idx_i == REG_FIND_LEN ||
                     cfg_idx_i == REG_FIND_LO || cfg_idx_i == REG_FIND_HI);

  // Effective lengths (clamped)
  logic [LEN_W-1:0] flen, rlen;
  assign flen = (find_len_q > LEN_W'(MAX_FIND_LEN)) ? LEN_W'(MAX_FIND_LEN) : find_len_q;
  assign rlen = (repl_len_q > LEN_W'(MAX_REPL_LEN)) ? LEN_W'(MAX_REPL_LEN) : repl_len_q;

  logic [127:0] find_all, repl_all;
  assign find_all = {find_hi_q, find_lo_q};
  assign repl_all = {repl_hi_q, repl_lo_q};

  function automatic logic [7:0] pick(input logic [127:0] w, input logic [3:0] i);
    pick = w[{i, 3'b000} +: 8];
  endfunction

  // Fallback table: flops, one 4-bit entry per pattern position
  logic [3:0] fb_q [16];
  logic       fb_we;
  logic [3:0] fb_widx, fb_wdat;

  always_ff @(posedge clk_i) begin
    if (fb_we) fb_q[fb_widx] <= fb_wdat;
  end

  // Control state
  state_e           st_q, st_d;
  logic [LEN_W-1:0] hc_q, hc_d;     // held count
  logic [LEN_W-1:0] k_q, k_d;       // fallback walk position / table k
  logic [LEN_W-1:0] ti_q, ti_d;     // table build index
  logic [LEN_W-1:0] cnt_q, cnt_d;   // emit counter
  logic [7:0]       b_q, b_d;
  logic             eol_q, eol_d;
  logic             match_q, match_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             ol_q, ol_d;

  // Held-byte cell row
  logic [7:0] cell_out [NC];
  cell_ctl_t  ctl;
  logic [IW-1:0] load_idx;
  logic [7:0]    load_byte;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    ssr_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .sel_i  (load_idx == IW'(g)),
      .byte_i (load_byte),
      .nbr_i  ((g == NC - 1) ? 8'h00 : cell_out[(g + 1) % NC]),
      .byte_o (cell_out[g])
    );
  end

  logic out_free;
  assign out_free = !ov_q || !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE) || !out_free;

  logic [7:0] pk;
  logic [3:0] fbk;
  logic       in_acc;
  logic [LEN_W-1:0] rem;
  assign in_acc = in_valid_i && !in_stall_o;
  assign pk  = pick(find_all, k_q[3:0]);
  assign fbk = fb_q[4'(k_q - 1'b1)];
  logic [7:0] pti;
  assign pti = pick(find_all, ti_q[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      hc_q <= '0;
      ov_q <= 1'b0;
      k_q <= '0;
      ti_q <= '0;
      cnt_q <= '0;
      eol_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      st_q <= st_d;
      hc_q <= hc_d;
      ov_q <= ov_d;
      k_q <= k_d;
      ti_q <= ti_d;
      cnt_q <= cnt_d;
      eol_q <= eol_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q  <= b_d;
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  always_comb begin
    st_d = st_q; hc_d = hc_q; k_d = k_q; ti_d = ti_q; cnt_d = cnt_q;
    b_d = b_q; eol_d = eol_q; match_d = match_q;
    ov_d = ov_q && out_stall_i; ob_d = ob_q; ol_d = ol_q;
    ctl = '0; load_idx = k_q[IW-1:0]; load_byte = b_q;
    fb_we = 1'b0; fb_widx = ti_q[3:0]; fb_wdat = '0;
    rem = '0;

    case (st_q)
      ST_IDLE: begin
        if (tbl_start) begin
          // Pattern changes: drop held bytes, rebuild table; entry 0 is always zero
          hc_d = '0; k_d = '0; ti_d = 5'd1;
          fb_we = 1'b1; fb_widx = 4'd0; fb_wdat = 4'd0;
          st_d = ST_TBL;
        end else if (in_acc) begin
          b_d = in_byte_i; eol_d = end_of_line_i;
          if (flen == '0) begin
            ov_d = 1'b1; ob_d = in_byte_i; ol_d = 1'b1;
          end else begin
            hc_d = (hc_q >= flen) ? '0 : hc_q;
            k_d = hc_d;
            st_d = ST_FALL;
          end
        end
      end
      ST_TBL: begin
        // One pattern index per cycle except while k falls back
        if (tbl_start) begin
          k_d = '0; ti_d = 5'd1;
        end else if (ti_q >= flen) begin
          st_d = ST_IDLE;
        end else if (k_q != '0 && pti != pk) begin
          k_d = {1'b0, fbk};
        end else begin
          k_d = (pti == pk) ? k_q + 1'b1 : k_q;
          fb_we = 1'b1; fb_wdat = k_d[3:0];
          ti_d = ti_q + 1'b1;
        end
      end
      ST_FALL: begin
        if (k_q != '0 && b_q != pk) begin
          k_d = {1'b0, fbk};
        end else begin
          match_d = (b_q == pk);
          cnt_d = hc_q - k_q;  // bytes released
          st_d = ST_REL;
        end
      end
      ST_REL: begin
        if (cnt_q != '0) begin
          if (out_free) begin
            ov_d = 1'b1; ob_d = cell_out[0]; ctl.shift = 1'b1;
            cnt_d = cnt_q - 1'b1;
            rem = cnt_d;
            // Last released byte ends the run unless a literal, replacement or flush follows
            ol_d = (rem == '0) && match_q &&
                   ((LEN_W'(k_q + 1'b1) == flen) ? (rlen == '0) : !eol_q);
          end
        end else if (match_q) begin
          ctl.load = 1'b1; load_idx = k_q[IW-1:0];
          hc_d = k_q + 1'b1;
          if (hc_d == flen) begin
            hc_d = '0; cnt_d = '0; st_d = ST_REPL;
          end else if (eol_q) begin
            cnt_d = '0; st_d = ST_FLUSH;
          end else begin
            st_d = ST_IDLE;
          end
        end else begin
          hc_d = '0; st_d = ST_LIT;
        end
      end
      ST_REPL: begin
        if (cnt_q == rlen) begin
          st_d = ST_IDLE;
        end else if (out_free) begin
          ov_d = 1'b1; ob_d = pick(repl_all, cnt_q[3:0]);
          cnt_d = cnt_q + 1'b1;
          ol_d = (cnt_d == rlen);
          if (cnt_d == rlen) st_d = ST_IDLE;
        end
      end
      ST_LIT: begin
        if (out_free) begin
          ov_d = 1'b1; ob_d = b_q; ol_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ov_d = 1'b1; ob_d = cell_out[0]; ctl.shift = 1'b1;
          hc_d = hc_q - 1'b1;
          ol_d = (hc_d == '0);
          if (hc_d == '0) st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign run_last_o  = ol_q;

  // Held count never reaches the pattern length while idle
  a_hc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && flen != '0) |-> hc_q < flen) else $error("held count overflow");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(ob_q)) else $error("output dropped");

endmodule
`default_nettype wire
